/* hw/rtl/intel_hex_record_loader_assert.svh */
// ---------------------------------------------------------------------------
// Assertion macros for the Intel HEX record loader checks
// Clocked on clock, disabled while reset is high.
// ---------------------------------------------------------------------------
`ifndef INTEL_HEX_RECORD_LOADER_ASSERT_SVH
`define INTEL_HEX_RECORD_LOADER_ASSERT_SVH

// Property holds in the same cycle as its antecedent.
`define IHEX_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Property holds in the cycle after its antecedent.
`define IHEX_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* hw/rtl/ihex_pkg.sv */
// ---------------------------------------------------------------------------
// ihex_pkg
// Types, codes and helpers shared by the Intel HEX record loader.
// ---------------------------------------------------------------------------
package ihex_pkg;

   localparam logic [16:0] MEM_SIZE_RESET = 17'd8192;

   localparam logic [7:0] CHAR_COLON   = 8'h3A;
   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;

   localparam logic [7:0] TYPE_DATA = 8'h00;
   localparam logic [7:0] TYPE_END  = 8'h01;

   localparam logic [8:0] PAIR_MAX     = 9'd511;
   localparam logic [8:0] LEN_OVERHEAD = 9'd5;

   // result kinds
   localparam logic [1:0] KIND_BYTE    = 2'd0;
   localparam logic [1:0] KIND_STATUS  = 2'd1;
   localparam logic [1:0] KIND_SUMMARY = 2'd2;

   // record status codes
   localparam logic [2:0] ST_STORED    = 3'd0;
   localparam logic [2:0] ST_RANGE     = 3'd1;
   localparam logic [2:0] ST_UNKNOWN   = 3'd2;
   localparam logic [2:0] ST_IGNORED   = 3'd3;
   localparam logic [2:0] ST_END       = 3'd4;
   localparam logic [2:0] ST_LENGTH    = 3'd5;
   localparam logic [2:0] ST_CHECKSUM  = 3'd6;
   localparam logic [2:0] ST_TOO_LONG  = 3'd7;

   typedef struct packed {
      logic [7:0] character;
      logic       end_of_input;
   } ihex_req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] address;
      logic [7:0]  data;
      logic [2:0]  status;
      logic [16:0] highest_end;
      logic        last;
   } ihex_rsp_type;

   // controller -> datapath
   typedef struct packed {
      logic       line_start;
      logic       take_digit;
      logic       finish;
      logic       set_ignored;
      logic       out_load;
      logic [1:0] out_kind;
      logic       out_last;
      logic       flush_step;
      logic       clear_all;
   } ihex_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_eoi;
      logic is_colon;
      logic is_newline;
      logic is_hex;
      logic verdict_halt;
      logic verdict_stored;
      logic len_zero;
      logic flush_done;
      logic out_free;
   } ihex_stat_type;

   // {valid, value} of one ASCII hex digit
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [7:0] off;
      logic [4:0] res;
      off = 8'd0;
      res = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         off = c - 8'h30;
         res = {1'b1, off[3:0]};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         off = c - 8'h37;
         res = {1'b1, off[3:0]};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         off = c - 8'h57;
         res = {1'b1, off[3:0]};
      end
      return res;
   endfunction

endpackage

/* hw/rtl/ihex_ctrl.sv */
// ---------------------------------------------------------------------------
// ihex_ctrl
// Line phase tracking and sequencing of record checks and result transfers.
// ---------------------------------------------------------------------------
module ihex_ctrl
   import ihex_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  ihex_stat_type stat,
   output ihex_cmd_type  cmd
);

   localparam logic [1:0] PH_START  = 2'd0;
   localparam logic [1:0] PH_HEX    = 2'd1;
   localparam logic [1:0] PH_TAIL   = 2'd2;
   localparam logic [1:0] PH_IGNORE = 2'd3;

   localparam logic [2:0] S_IDLE     = 3'd0;
   localparam logic [2:0] S_FINISH   = 3'd1;
   localparam logic [2:0] S_FLUSH_RD = 3'd2;
   localparam logic [2:0] S_FLUSH_WR = 3'd3;
   localparam logic [2:0] S_STATUS   = 3'd4;
   localparam logic [2:0] S_SUMMARY  = 3'd5;

   logic [2:0] state_ff, state_in;
   logic [1:0] phase_ff, phase_in;
   logic       stopped_ff, stopped_in;
   logic       eoi_ff, eoi_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      state_in   = state_ff;
      phase_in   = phase_ff;
      stopped_in = stopped_ff;
      eoi_in     = eoi_ff;
      cmd        = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               if (stat.is_eoi) begin
                  eoi_in = 1'b1;
                  if (stopped_ff) begin
                     state_in = S_SUMMARY;
                  end else begin
                     unique case (phase_ff) inside
                        PH_HEX, PH_TAIL: state_in = S_FINISH;
                        PH_IGNORE: begin
                           cmd.set_ignored = 1'b1;
                           state_in        = S_STATUS;
                        end
                        default: state_in = S_SUMMARY;
                     endcase
                  end
               end else if (!stopped_ff) begin
                  unique case (phase_ff)
                     PH_START: begin
                        if (stat.is_colon) begin
                           cmd.line_start = 1'b1;
                           phase_in       = PH_HEX;
                        end else if (stat.is_newline) begin
                           cmd.set_ignored = 1'b1;
                           state_in        = S_STATUS;
                        end else begin
                           phase_in = PH_IGNORE;
                        end
                     end
                     PH_HEX: begin
                        if (stat.is_newline) begin
                           state_in = S_FINISH;
                        end else if (stat.is_hex) begin
                           cmd.take_digit = 1'b1;
                        end else begin
                           phase_in = PH_TAIL;
                        end
                     end
                     PH_TAIL: begin
                        if (stat.is_newline) begin
                           state_in = S_FINISH;
                        end
                     end
                     default: begin
                        if (stat.is_newline) begin
                           phase_in        = PH_START;
                           cmd.set_ignored = 1'b1;
                           state_in        = S_STATUS;
                        end
                     end
                  endcase
               end
            end
         end
         S_FINISH: begin
            cmd.finish = 1'b1;
            phase_in   = PH_START;
            if (stat.verdict_halt) begin
               stopped_in = 1'b1;
               state_in   = S_STATUS;
            end else if (stat.verdict_stored && !stat.len_zero) begin
               state_in = S_FLUSH_RD;
            end else begin
               state_in = S_STATUS;
            end
         end
         S_FLUSH_RD: begin
            state_in = S_FLUSH_WR;
         end
         S_FLUSH_WR: begin
            if (stat.out_free) begin
               cmd.out_load   = 1'b1;
               cmd.out_kind   = KIND_BYTE;
               cmd.flush_step = 1'b1;
               state_in       = stat.flush_done ? S_STATUS : S_FLUSH_RD;
            end
         end
         S_STATUS: begin
            if (stat.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_kind = KIND_STATUS;
               cmd.out_last = !eoi_ff;
               state_in     = eoi_ff ? S_SUMMARY : S_IDLE;
            end
         end
         S_SUMMARY: begin
            if (stat.out_free) begin
               cmd.out_load  = 1'b1;
               cmd.out_kind  = KIND_SUMMARY;
               cmd.out_last  = 1'b1;
               cmd.clear_all = 1'b1;
               phase_in      = PH_START;
               stopped_in    = 1'b0;
               eoi_in        = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         phase_ff   <= PH_START;
         stopped_ff <= 1'b0;
         eoi_ff     <= 1'b0;
      end else begin
         state_ff   <= state_in;
         phase_ff   <= phase_in;
         stopped_ff <= stopped_in;
         eoi_ff     <= eoi_in;
      end
   end

endmodule

/* hw/rtl/ihex_dp.sv */
// ---------------------------------------------------------------------------
// ihex_dp
// Record fields, byte buffer, record checks and the result register.
// ---------------------------------------------------------------------------
module ihex_dp
   import ihex_pkg::*;
#(
   parameter int unsigned MAX_DATA = 32
)
(
   input  logic          clock,
   input  logic          reset,
   input  ihex_req_type  req_data,
   input  logic          rsp_ready,
   output logic          rsp_valid,
   output ihex_rsp_type  rsp_data,
   input  logic          csr_we,
   input  logic [16:0]   csr_wdata,
   input  ihex_cmd_type  cmd,
   output ihex_stat_type stat
);

   localparam int unsigned IDX_W = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
   localparam int unsigned FI_W  = $clog2(MAX_DATA + 1);
   localparam logic [7:0]  MAX_LEN = 8'(MAX_DATA);
   localparam logic [8:0]  BUF_END = 9'(MAX_DATA + 4);

   localparam logic [8:0] POS_LEN     = 9'd0;
   localparam logic [8:0] POS_ADDR_HI = 9'd1;
   localparam logic [8:0] POS_ADDR_LO = 9'd2;
   localparam logic [8:0] POS_TYPE    = 9'd3;
   localparam logic [8:0] POS_DATA    = 9'd4;

   logic [16:0]     memsize_ff;
   logic [3:0]      nib_ff;
   logic            held_ff;
   logic [8:0]      pc_ff;
   logic [7:0]      sum_ff;
   logic [7:0]      len_ff;
   logic [15:0]     addr_ff;
   logic [7:0]      type_ff;
   logic [16:0]     top_ff;
   logic [2:0]      stop_ff;
   logic [2:0]      code_ff;
   logic [FI_W-1:0] flush_ff;
   logic [7:0]      rd_data_ff;
   logic            rsp_valid_ff;
   ihex_rsp_type    rsp_data_ff;

   logic [7:0] buf_mem [MAX_DATA];

   logic [4:0]  dec;
   logic [7:0]  byte_val;
   logic [8:0]  wr_off;
   logic        wr_ok;
   logic [8:0]  len_plus;
   logic [16:0] end_addr;
   logic [2:0]  verdict;
   logic        out_free;

   assign dec      = hex_decode(req_data.character);
   assign byte_val = {nib_ff, dec[3:0]};
   assign wr_off   = pc_ff - POS_DATA;
   assign wr_ok    = (pc_ff >= POS_DATA) && (pc_ff < BUF_END);
   assign len_plus = {1'b0, len_ff} + LEN_OVERHEAD;
   assign end_addr = {1'b0, addr_ff} + {9'd0, len_ff};
   assign out_free = !rsp_valid_ff || rsp_ready;

   // record verdict, checks in priority order
   always_comb begin
      if (pc_ff < 9'd2)                verdict = ST_IGNORED;
      else if (len_plus != pc_ff)      verdict = ST_LENGTH;
      else if (sum_ff != 8'd0)         verdict = ST_CHECKSUM;
      else if (type_ff == TYPE_END)    verdict = ST_END;
      else if (type_ff != TYPE_DATA)   verdict = ST_UNKNOWN;
      else if (len_ff > MAX_LEN)       verdict = ST_TOO_LONG;
      else if (end_addr > memsize_ff)  verdict = ST_RANGE;
      else                             verdict = ST_STORED;
   end

   always_comb begin
      stat.is_eoi         = req_data.end_of_input;
      stat.is_colon       = (req_data.character == CHAR_COLON);
      stat.is_newline     = (req_data.character == CHAR_NEWLINE);
      stat.is_hex         = dec[4];
      stat.verdict_halt   = (verdict == ST_END) || (verdict == ST_LENGTH) ||
                            (verdict == ST_CHECKSUM) || (verdict == ST_TOO_LONG);
      stat.verdict_stored = (verdict == ST_STORED);
      stat.len_zero       = (len_ff == 8'd0);
      stat.flush_done     = ({{(8-FI_W){1'b0}}, flush_ff} + 8'd1) == len_ff;
      stat.out_free       = out_free;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         memsize_ff   <= MEM_SIZE_RESET;
         nib_ff       <= '0;
         held_ff      <= 1'b0;
         pc_ff        <= '0;
         sum_ff       <= '0;
         len_ff       <= '0;
         addr_ff      <= '0;
         type_ff      <= '0;
         top_ff       <= '0;
         stop_ff      <= ST_STORED;
         code_ff      <= ST_STORED;
         flush_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            memsize_ff <= csr_wdata;
         end
         if (cmd.clear_all || cmd.line_start) begin
            nib_ff  <= '0;
            held_ff <= 1'b0;
            pc_ff   <= '0;
            sum_ff  <= '0;
            len_ff  <= '0;
            addr_ff <= '0;
            type_ff <= '0;
         end else if (cmd.take_digit) begin
            if (held_ff) begin
               held_ff <= 1'b0;
               case (pc_ff)
                  POS_LEN:     len_ff         <= byte_val;
                  POS_ADDR_HI: addr_ff[15:8]  <= byte_val;
                  POS_ADDR_LO: addr_ff[7:0]   <= byte_val;
                  POS_TYPE:    type_ff        <= byte_val;
                  default:     ;
               endcase
               sum_ff <= sum_ff + byte_val;
               if (pc_ff != PAIR_MAX) begin
                  pc_ff <= pc_ff + 9'd1;
               end
            end else begin
               nib_ff  <= dec[3:0];
               held_ff <= 1'b1;
            end
         end
         if (cmd.clear_all) begin
            top_ff  <= '0;
            stop_ff <= ST_STORED;
         end else if (cmd.finish) begin
            if (stat.verdict_halt) begin
               stop_ff <= verdict;
            end
            if (stat.verdict_stored && (end_addr > top_ff)) begin
               top_ff <= end_addr;
            end
         end
         if (cmd.set_ignored) begin
            code_ff <= ST_IGNORED;
         end else if (cmd.finish) begin
            code_ff <= verdict;
         end
         if (cmd.clear_all) begin
            flush_ff <= '0;
         end else if (cmd.flush_step) begin
            flush_ff <= stat.flush_done ? '0 : flush_ff + 1'b1;
         end
         if (cmd.out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // byte buffer: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.take_digit && held_ff && wr_ok) begin
         buf_mem[wr_off[IDX_W-1:0]] <= byte_val;
      end
      rd_data_ff <= buf_mem[flush_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         rsp_data_ff.kind        <= cmd.out_kind;
         rsp_data_ff.highest_end <= top_ff;
         rsp_data_ff.last        <= cmd.out_last;
         case (cmd.out_kind)
            KIND_BYTE: begin
               rsp_data_ff.address <= addr_ff + {{(16-FI_W){1'b0}}, flush_ff};
               rsp_data_ff.data    <= rd_data_ff;
               rsp_data_ff.status  <= ST_STORED;
            end
            KIND_STATUS: begin
               rsp_data_ff.address <= (code_ff == ST_IGNORED) ? 16'd0 : addr_ff;
               rsp_data_ff.data    <= 8'd0;
               rsp_data_ff.status  <= code_ff;
            end
            default: begin
               rsp_data_ff.address <= 16'd0;
               rsp_data_ff.data    <= 8'd0;
               rsp_data_ff.status  <= stop_ff;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

/* hw/rtl/intel_hex_record_loader.sv */
// ---------------------------------------------------------------------------
// intel_hex_record_loader
// Takes Intel HEX text one character per transfer on req_ and returns byte
// writes, record status and end-of-file summary results on rsp_. Ordinary
// characters are taken at one per cycle, even while a result waits on rsp_.
// At a line end (or end of input) the block stops taking characters while
// it checks the record, then for a stored record reads and sends each
// data byte in turn (the byte buffer has a single registered read port),
// then sends the status result, plus the summary at end of input; each
// result transfer also waits on rsp_ready. Data records ending past
// csr_wdata's memory size are reported and skipped; an end record or a
// length, checksum or too-long error stops parsing until end of input,
// after which all parse state, including the highest end address, returns
// to reset. The memory size register resets to 8192 and is written by
// csr_we; write it only while no line is being finished. MAX_DATA sets the
// byte buffer depth and the longest data record that is stored.
// ---------------------------------------------------------------------------
module intel_hex_record_loader
   import ihex_pkg::*;
#(
   parameter int unsigned MAX_DATA = 32
)
(
   input  logic         clock,
   input  logic         reset,
   // character transfers
   input  logic         req_valid,
   output logic         req_ready,
   input  ihex_req_type req_data,
   // result transfers
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output ihex_rsp_type rsp_data,
   // memory size register
   input  logic         csr_we,
   input  logic [16:0]  csr_wdata
);

   ihex_cmd_type  cmd;
   ihex_stat_type stat;

   // controller: line phase, stop flag and result sequencing
   ihex_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   // datapath: record fields, checks, byte buffer and result register
   ihex_dp #(
      .MAX_DATA (MAX_DATA)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .stat      (stat)
   );

endmodule

/* hw/rtl/ihex_checker.sv */
// ---------------------------------------------------------------------------
// ihex_checker
// Port-level checks on the result channel of the record loader.
// ---------------------------------------------------------------------------
`include "intel_hex_record_loader_assert.svh"

module ihex_checker
   import ihex_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input ihex_rsp_type rsp_data
);

   `IHEX_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "result changed while stalled")

   `IHEX_ASSERT_NOW(a_byte_shape, rsp_valid && (rsp_data.kind == KIND_BYTE), !rsp_data.last && (rsp_data.status == ST_STORED), "byte write is last or carries a status")

   `IHEX_ASSERT_NOW(a_summary_shape, rsp_valid && (rsp_data.kind == KIND_SUMMARY), rsp_data.last && (rsp_data.address == 16'd0) && (rsp_data.data == 8'd0), "summary not last or not clean")

endmodule

bind intel_hex_record_loader ihex_checker u_ihex_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

/* tb/ihex_load_tb_pkg.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Intel HEX loader scoreboard
// Tracks the loader's line parser, record checks and highest end address,
// and keeps the results each accepted character is due to produce.
// ---------------------------------------------------------------------------
package ihex_load_tb_pkg;
   import ihex_pkg::*;

   localparam int BYTE_SLOTS = 32;

   typedef enum logic [1:0] {
      AT_LINE_START,
      IN_DIGITS,
      IN_TAIL,
      SKIP_LINE
   } line_state_type;

   // value of an ASCII hex digit, -1 for anything else
   function automatic int hex_digit_value(logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      return -1;
   endfunction

   class ihex_load_scoreboard;
      logic [16:0]    memory_size;
      line_state_type line_state;
      logic [3:0]     high_nibble;
      bit             nibble_held;
      logic [8:0]     pair_count;
      logic [7:0]     byte_sum;
      logic [7:0]     rec_length;
      logic [15:0]    rec_address;
      logic [7:0]     rec_type;
      logic [7:0]     rec_data [BYTE_SLOTS];
      logic [16:0]    highest_end;
      bit             halted;
      logic [2:0]     halt_status;
      ihex_rsp_type   results_due [$];
      ihex_rsp_type   step_results [$];
      int             mismatches;
      int             live_items;

      function new();
         memory_size = MEM_SIZE_RESET;
         mismatches = 0;
         live_items = 0;
         clear_file();
      endfunction

      function void clear_file();
         line_state = AT_LINE_START;
         high_nibble = '0;
         nibble_held = 1'b0;
         pair_count = '0;
         byte_sum = '0;
         rec_length = '0;
         rec_address = '0;
         rec_type = '0;
         foreach (rec_data[i]) rec_data[i] = '0;
         highest_end = '0;
         halted = 1'b0;
         halt_status = ST_STORED;
      endfunction

      function void emit(logic [1:0] kind, logic [15:0] addr, logic [7:0] data,
                         logic [2:0] status);
         ihex_rsp_type r;
         r.kind = kind;
         r.address = addr;
         r.data = data;
         r.status = status;
         r.highest_end = highest_end;
         r.last = 1'b0;
         step_results.push_back(r);
      endfunction

      function void halt_with(logic [2:0] status);
         halted = 1'b1;
         halt_status = status;
         emit(KIND_STATUS, rec_address, '0, status);
      endfunction

      function void take_byte(logic [7:0] b);
         int slot;
         slot = int'(pair_count) - 4;
         case (pair_count)
            9'd0: rec_length = b;
            9'd1: rec_address[15:8] = b;
            9'd2: rec_address[7:0] = b;
            9'd3: rec_type = b;
            default: if (slot < BYTE_SLOTS) rec_data[slot] = b;
         endcase
         byte_sum = byte_sum + b;
         if (pair_count != PAIR_MAX) pair_count = pair_count + 9'd1;
      endfunction

      function void close_record();
         logic [16:0] rec_end;
         line_state = AT_LINE_START;
         nibble_held = 1'b0;
         if (pair_count < 9'd2) begin
            emit(KIND_STATUS, '0, '0, ST_IGNORED);
            return;
         end
         if ({1'b0, rec_length} + LEN_OVERHEAD != pair_count) begin
            halt_with(ST_LENGTH);
            return;
         end
         if (byte_sum != 8'd0) begin
            halt_with(ST_CHECKSUM);
            return;
         end
         if (rec_type == TYPE_END) begin
            halt_with(ST_END);
            return;
         end
         if (rec_type != TYPE_DATA) begin
            emit(KIND_STATUS, rec_address, '0, ST_UNKNOWN);
            return;
         end
         if (rec_length > BYTE_SLOTS) begin
            halt_with(ST_TOO_LONG);
            return;
         end
         rec_end = {1'b0, rec_address} + rec_length;
         if (rec_end > memory_size) begin
            emit(KIND_STATUS, rec_address, '0, ST_RANGE);
            return;
         end
         if (rec_end > highest_end) highest_end = rec_end;
         for (int i = 0; i < int'(rec_length); i++)
            emit(KIND_BYTE, rec_address + 16'(i), rec_data[i], ST_STORED);
         emit(KIND_STATUS, rec_address, '0, ST_STORED);
      endfunction

      // one accepted character: advance the parser, queue what it produces
      function void note_character(ihex_req_type t);
         int v;
         ihex_rsp_type r;
         step_results.delete();
         if (!halted) live_items++;
         if (t.end_of_input) begin
            if (!halted) begin
               if (line_state == IN_DIGITS || line_state == IN_TAIL) close_record();
               else if (line_state == SKIP_LINE) emit(KIND_STATUS, '0, '0, ST_IGNORED);
            end
            // a clean end reports 0, same value as ST_STORED
            emit(KIND_SUMMARY, '0, '0, halted ? halt_status : ST_STORED);
            clear_file();
         end else if (!halted) begin
            case (line_state)
               AT_LINE_START: begin
                  if (t.character == CHAR_COLON) begin
                     line_state = IN_DIGITS;
                     high_nibble = '0;
                     nibble_held = 1'b0;
                     pair_count = '0;
                     byte_sum = '0;
                     rec_length = '0;
                     rec_address = '0;
                     rec_type = '0;
                  end else if (t.character == CHAR_NEWLINE) begin
                     emit(KIND_STATUS, '0, '0, ST_IGNORED);
                  end else begin
                     line_state = SKIP_LINE;
                  end
               end
               IN_DIGITS: begin
                  if (t.character == CHAR_NEWLINE) begin
                     close_record();
                  end else begin
                     v = hex_digit_value(t.character);
                     if (v < 0) begin
                        line_state = IN_TAIL;
                        nibble_held = 1'b0;
                     end else if (nibble_held) begin
                        take_byte({high_nibble, 4'(v)});
                        nibble_held = 1'b0;
                     end else begin
                        high_nibble = 4'(v);
                        nibble_held = 1'b1;
                     end
                  end
               end
               IN_TAIL: if (t.character == CHAR_NEWLINE) close_record();
               default: begin
                  if (t.character == CHAR_NEWLINE) begin
                     line_state = AT_LINE_START;
                     emit(KIND_STATUS, '0, '0, ST_IGNORED);
                  end
               end
            endcase
         end
         if (step_results.size() > 0) begin
            r = step_results.pop_back();
            r.last = 1'b1;
            step_results.push_back(r);
         end
         foreach (step_results[i]) results_due.push_back(step_results[i]);
      endfunction

      function void compare_field(string name, logic [16:0] want, logic [16:0] got);
         if (got !== want) begin
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(ihex_rsp_type got);
         ihex_rsp_type want;
         if (results_due.size() == 0) begin
            $display("%0t: result with nothing expected, expected none, got %h", $time, got);
            mismatches++;
            return;
         end
         want = results_due.pop_front();
         compare_field("kind", 17'(want.kind), 17'(got.kind));
         compare_field("address", 17'(want.address), 17'(got.address));
         compare_field("data", 17'(want.data), 17'(got.data));
         compare_field("status", 17'(want.status), 17'(got.status));
         compare_field("highest_end", want.highest_end, got.highest_end);
         compare_field("last", 17'(want.last), 17'(got.last));
      endfunction

      function int pending();
         return results_due.size();
      endfunction
   endclass

endpackage

/* tb/tb_intel_hex_record_loader.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Intel HEX record loader testbench
// Feeds HEX text one character per transfer: a few hand-made lines first,
// then random files of mostly well-formed records with broken ones mixed
// in, over several memory sizes. Every result transfer is checked against
// the scoreboard's prediction. Both sides idle at random.
// ---------------------------------------------------------------------------
module tb_intel_hex_record_loader;
   import ihex_pkg::*;
   import ihex_load_tb_pkg::*;

   localparam int HALF_PERIOD     = 5;
   localparam int RESET_CYCLES    = 7;
   localparam int CYCLE_LIMIT     = 6_000_000;
   // quiet cycles after the last result, before the next character or register write
   localparam int SETTLE_CYCLES   = 16;
   localparam int ITEMS_PER_PHASE = 45;

   logic         clock = 1'b0;
   logic         reset;
   logic         req_valid;
   logic         req_ready;
   ihex_req_type req_data;
   logic         rsp_valid;
   logic         rsp_ready;
   ihex_rsp_type rsp_data;
   logic         csr_we;
   logic [16:0]  csr_wdata;

   ihex_load_scoreboard sb;
   int unsigned         cycle_count = 0;
   // while set, that side runs back to back with no idle cycles
   bit                  req_rush;
   bit                  rsp_rush;
   logic [16:0]         phase_sizes [6];
   // live character count at which the current phase stops starting lines
   int                  phase_goal;

   intel_hex_record_loader #(
      .MAX_DATA(BYTE_SLOTS)
   ) i_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data(rsp_data),
      .csr_we(csr_we),
      .csr_wdata(csr_wdata)
   );

   always #HALF_PERIOD clock = ~clock;

   // hang guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   // redraw the no-idle stretches after each random wait
   always begin
      repeat ($urandom_range(100, 400)) @(posedge clock);
      req_rush = ($urandom_range(0, 3) == 0);
      rsp_rush = ($urandom_range(0, 3) == 0);
   end

   function automatic int draw_gap(bit rush);
      return rush ? 0 : $urandom_range(0, 15);
   endfunction

   // ---------------------------------------------------------------------
   // result side: random stalls, every transfer goes to the scoreboard
   // ---------------------------------------------------------------------
   initial begin
      int gap;
      rsp_ready <= 1'b0;
      do @(posedge clock); while (reset);
      forever begin
         gap = draw_gap(rsp_rush);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         // values read here are the ones the edge sampled
         do @(posedge clock); while (!rsp_valid);
         sb.check_result(rsp_data);
      end
   end

   // ---------------------------------------------------------------------
   // character side
   // ---------------------------------------------------------------------

   // One character transfer. Valid stays high across back-to-back transfers;
   // the scoreboard sees the character at the edge that takes it.
   task automatic send_char(input logic [7:0] c, input bit eoi);
      int           gap;
      ihex_req_type item;
      item.character = c;
      item.end_of_input = eoi;
      gap = draw_gap(req_rush);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (!req_ready);
      sb.note_character(item);
   endtask

   // hex digit in random letter case
   function automatic logic [7:0] hex_char(logic [3:0] nib);
      if (nib < 4'd10) return 8'("0") + nib;
      return ($urandom_range(0, 1) ? 8'("A") : 8'("a")) + nib - 8'd10;
   endfunction

   function automatic logic [7:0] any_but_newline();
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (c == CHAR_NEWLINE);
      return c;
   endfunction

   // something that ends the digit run without ending the line
   function automatic logic [7:0] junk_char();
      logic [7:0] c;
      do c = any_but_newline(); while (hex_digit_value(c) >= 0);
      return c;
   endfunction

   task automatic send_byte(input logic [7:0] b);
      send_char(hex_char(b[7:4]), 1'b0);
      send_char(hex_char(b[3:0]), 1'b0);
   endtask

   // ':' + byte pairs, sometimes a stray half byte and/or a junk tail
   task automatic send_line(input logic [7:0] fields [$], input bit newline);
      send_char(CHAR_COLON, 1'b0);
      foreach (fields[i]) send_byte(fields[i]);
      if ($urandom_range(0, 7) == 0) send_char(hex_char(4'($urandom_range(0, 15))), 1'b0);
      if ($urandom_range(0, 7) == 0) begin
         send_char(junk_char(), 1'b0);
         // anything after the junk is skipped, hex digits included
         repeat ($urandom_range(0, 3)) send_char(any_but_newline(), 1'b0);
      end
      if (newline) send_char(CHAR_NEWLINE, 1'b0);
   endtask

   // len_skew puts a wrong count in the length byte; bad_sum spoils the checksum
   task automatic send_record(input logic [7:0] rec_type, input int len,
                              input logic [15:0] addr, input bit bad_sum,
                              input int len_skew, input bit newline);
      logic [7:0] fields [$];
      logic [7:0] sum;
      logic [7:0] chk;
      fields.push_back(8'(len + len_skew));
      fields.push_back(addr[15:8]);
      fields.push_back(addr[7:0]);
      fields.push_back(rec_type);
      repeat (len) fields.push_back(8'($urandom_range(0, 255)));
      sum = '0;
      foreach (fields[i]) sum = sum + fields[i];
      chk = 8'd0 - sum;
      if (bad_sum) chk = chk ^ 8'($urandom_range(1, 255));
      fields.push_back(chk);
      send_line(fields, newline);
   endtask

   // mostly small records; empty and full-buffer ones now and then
   function automatic int pick_len();
      case ($urandom_range(0, 9))
         0: return 0;
         1: return BYTE_SLOTS;
         2: return $urandom_range(9, BYTE_SLOTS - 1);
         default: return $urandom_range(1, 8);
      endcase
   endfunction

   // load address relative to the current memory size, edges included
   function automatic logic [15:0] pick_address(int len);
      int room;
      room = int'(sb.memory_size) - len;
      if (room > 65535) room = 65535;
      if (room < 0) return 16'($urandom_range(0, 65535));
      case ($urandom_range(0, 7))
         0: return 16'($urandom_range(0, 65535));
         1: return 16'(room);                       // ends exactly at the top
         2: return (room < 65535) ? 16'(room + 1) : 16'(room);  // one past
         default: return 16'($urandom_range(0, room));
      endcase
   endfunction

   task automatic send_noise_line(input bit newline);
      logic [7:0] c;
      do c = 8'($urandom_range(0, 255)); while (c == CHAR_COLON || c == CHAR_NEWLINE);
      send_char(c, 1'b0);
      repeat ($urandom_range(0, 6)) send_char(any_but_newline(), 1'b0);
      if (newline) send_char(CHAR_NEWLINE, 1'b0);
   endtask

   // fewer than two byte pairs after the colon
   task automatic send_short_line(input bit newline);
      send_char(CHAR_COLON, 1'b0);
      if ($urandom_range(0, 1)) send_byte(8'($urandom_range(0, 255)));
      if ($urandom_range(0, 1)) send_char(hex_char(4'($urandom_range(0, 15))), 1'b0);
      if (newline) send_char(CHAR_NEWLINE, 1'b0);
   endtask

   // hold off new characters until every predicted result is back
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_memory_size(input logic [16:0] bytes_total);
      csr_we <= 1'b1;
      csr_wdata <= bytes_total;
      @(posedge clock);
      csr_we <= 1'b0;
      sb.memory_size = bytes_total;
   endtask

   // One file: a run of lines, ended by an end-of-input transfer. Once the
   // parser has stopped, the rest is a few ignored characters.
   task automatic send_file();
      int count;
      int i;
      int len;
      int pick;
      bit open_end;
      bit nl;
      count = $urandom_range(1, 10);
      // sometimes the last line has no newline and end of input closes it
      open_end = ($urandom_range(0, 3) == 0);
      for (i = 0; i < count && !sb.halted && sb.live_items < phase_goal; i++) begin
         nl = !(open_end && i == count - 1);
         pick = $urandom_range(0, 99);
         len = pick_len();
         if (pick < 48)
            send_record(TYPE_DATA, len, pick_address(len), 1'b0, 0, nl);
         else if (pick < 54)
            send_record(8'($urandom_range(2, 255)), $urandom_range(0, 4),
                        16'($urandom_range(0, 65535)), 1'b0, 0, nl);
         else if (pick < 58)
            send_record(TYPE_DATA, len, pick_address(len), 1'b1, 0, nl);
         else if (pick < 62)
            send_record(TYPE_DATA, len, pick_address(len), 1'b0,
                        $urandom_range(0, 1) ? 1 : -1, nl);
         else if (pick < 65)
            send_record(TYPE_DATA, $urandom_range(BYTE_SLOTS + 1, BYTE_SLOTS + 16),
                        16'($urandom_range(0, 65535)), 1'b0, 0, nl);
         else if (pick < 72)
            send_short_line(nl);
         else if (pick < 82)
            send_noise_line(nl);
         else if (pick < 88) begin
            if (nl) send_char(CHAR_NEWLINE, 1'b0);
         end else if (pick < 92)
            send_record(TYPE_END, $urandom_range(0, 2), 16'($urandom_range(0, 65535)),
                        1'b0, 0, nl);
         else
            send_record(TYPE_DATA, len, pick_address(len), 1'b0, 0, nl);
         if ($urandom_range(0, 24) == 0) settle();
      end
      if (sb.halted) repeat ($urandom_range(0, 4)) send_char(8'($urandom_range(0, 255)), 1'b0);
      send_char(8'($urandom_range(0, 255)), 1'b1);
   endtask

   task automatic send_directed();
      send_char(8'hFF, 1'b1);                 // end of input, nothing open
      send_char(CHAR_NEWLINE, 1'b0);          // empty line
      send_char(8'h00, 1'b0);                 // line without a colon
      send_char(CHAR_NEWLINE, 1'b0);
      send_char(CHAR_COLON, 1'b0);            // short record with a lone digit
      send_char(8'("1"), 1'b0);
      send_char(CHAR_NEWLINE, 1'b0);
      send_record(TYPE_END, 0, 16'h0000, 1'b0, 0, 1'b1);
      send_char(8'("Z"), 1'b0);               // parser stopped: no result
      send_char(8'h80, 1'b1);                 // summary carries the end code
   endtask

   // ---------------------------------------------------------------------
   // main sequence
   // ---------------------------------------------------------------------
   initial begin
      sb = new();
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_data <= '0;
      csr_we <= 1'b0;
      csr_wdata <= '0;
      phase_sizes[0] = 17'd65536;
      phase_sizes[1] = 17'd1;
      phase_sizes[2] = 17'($urandom_range(1, 65536));
      phase_sizes[3] = 17'd300;
      phase_sizes[4] = MEM_SIZE_RESET;
      phase_sizes[5] = 17'($urandom_range(1, 65536));
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // hand-made lines run at the reset memory size
      send_directed();

      foreach (phase_sizes[p]) begin
         // every file is closed here, so the register may change
         settle();
         write_memory_size(phase_sizes[p]);
         phase_goal = sb.live_items + ITEMS_PER_PHASE;
         while (sb.live_items < phase_goal) send_file();
      end

      settle();
      if (sb.mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
